@@ design/t7d_pkg.sv @@
// ----------------------------------------------------------------------------
// t7d_pkg: shared types and constants of the type 7 password decoder
// Holds the item and result structs, phase and status codes, the character
// constants and the 53-byte repeating key.
// ----------------------------------------------------------------------------
package t7d_pkg;

    // Decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_SEED_HI = 4'b0001,
        PH_SEED_LO = 4'b0010,
        PH_HEX_HI  = 4'b0100,
        PH_HEX_LO  = 4'b1000
    } phase_t;

    // Status reported on the last result
    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_ODD  = 3'd1,
        ST_SEED = 3'd2,
        ST_HEX  = 3'd3,
        ST_OVER = 3'd4
    } status_t;

    // One input item
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       out_last;
        status_t    status;
    } result_t;

    // Character constants
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [3:0] LETTER_OFFSET = 4'd9;
    localparam logic [3:0] SEED_TENS_VAL = 4'd10;
    localparam logic [3:0] SEED_MAX_UNIT = 4'd5;

    // Repeating key, one period
    localparam int KEY_PERIOD = 53;
    localparam logic [7:0] KEY_BASE [KEY_PERIOD] = '{
        8'h64, 8'h73, 8'h66, 8'h64, 8'h3b, 8'h6b, 8'h66, 8'h6f,
        8'h41, 8'h2c, 8'h2e, 8'h69, 8'h79, 8'h65, 8'h77, 8'h72,
        8'h6b, 8'h6c, 8'h64, 8'h4a, 8'h4b, 8'h44, 8'h48, 8'h53,
        8'h55, 8'h42, 8'h73, 8'h67, 8'h76, 8'h63, 8'h61, 8'h36,
        8'h39, 8'h38, 8'h33, 8'h34, 8'h6e, 8'h63, 8'h78, 8'h76,
        8'h39, 8'h38, 8'h37, 8'h33, 8'h32, 8'h35, 8'h34, 8'h6b,
        8'h3b, 8'h66, 8'h67, 8'h38, 8'h37
    };

    // Key byte at a table index below 128: fold by the period twice
    function automatic logic [7:0] key_byte(input logic [7:0] idx);
        logic [7:0] r;
        r = idx;
        if (r >= 8'(KEY_PERIOD)) r = 8'(r - 8'(KEY_PERIOD));
        if (r >= 8'(KEY_PERIOD)) r = 8'(r - 8'(KEY_PERIOD));
        return KEY_BASE[r[5:0]];
    endfunction

endpackage

@@ design/t7d_in_stage.sv @@
// ----------------------------------------------------------------------------
// t7d_in_stage: input register
// Captures one character item and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module t7d_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // in_char
    input  logic              s_tlast,   // in_last
    input  logic              advance,
    output logic              item_valid,
    output t7d_pkg::in_item_t item
);
    import t7d_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.in_char <= s_tdata;
            item_reg.in_last <= s_tlast;
        end
    end

endmodule

@@ design/t7d_decode.sv @@
// ----------------------------------------------------------------------------
// t7d_decode: per-character decode and string state
// Parses the two seed digits and the hex pairs, XORs each pair with the key
// and records the first error; state returns to reset after the last item.
// ----------------------------------------------------------------------------
module t7d_decode #(
    parameter int KEY_TABLE_DEPTH = 106
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  t7d_pkg::in_item_t item,
    output t7d_pkg::result_t  result
);
    import t7d_pkg::*;

    localparam int IDX_W = $clog2(KEY_TABLE_DEPTH + 1);

    phase_t           phase_reg, phase_next;
    logic [3:0]       tens_reg, tens_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       high_reg, high_next;
    status_t          err_reg, err_next;

    logic       is_digit;
    logic       is_letter;
    logic       hex_ok;
    logic [3:0] hex_nib;
    logic [7:0] lower_char;
    logic       seed_ok;
    logic [3:0] seed_val;
    logic       odd;
    logic       overflow;

    // Classify the character
    always_comb begin
        lower_char = item.in_char | CASE_BIT;
        is_digit   = (item.in_char >= CH_ZERO) && (item.in_char <= CH_NINE);
        is_letter  = (lower_char >= CH_LOW_A) && (lower_char <= CH_LOW_F);
        hex_ok     = is_digit || is_letter;
        hex_nib    = is_digit ? item.in_char[3:0]
                              : 4'(item.in_char[3:0] + LETTER_OFFSET);
        seed_ok    = is_digit && ((tens_reg == 4'd0) ||
                     ((tens_reg == 4'd1) && (item.in_char[3:0] <= SEED_MAX_UNIT)));
        seed_val   = (tens_reg == 4'd1) ? 4'(SEED_TENS_VAL + item.in_char[3:0])
                                        : item.in_char[3:0];
        odd        = (phase_reg == PH_SEED_HI) || (phase_reg == PH_HEX_HI);
        overflow   = idx_reg >= IDX_W'(KEY_TABLE_DEPTH);
    end

    // Next state and result
    always_comb begin
        phase_next        = phase_reg;
        tens_next         = tens_reg;
        idx_next          = idx_reg;
        high_next         = high_reg;
        err_next          = err_reg;
        result.byte_valid = 1'b0;
        result.out_byte   = 8'd0;
        result.out_last   = item.in_last;
        result.status     = ST_OK;

        if (!(item.in_last && odd)) begin
            unique case (phase_reg)
                PH_SEED_HI: begin
                    if (is_digit) begin
                        tens_next = item.in_char[3:0];
                    end else if (err_reg == ST_OK) begin
                        err_next = ST_SEED;
                    end
                    phase_next = PH_SEED_LO;
                end
                PH_SEED_LO: begin
                    if (err_reg == ST_OK) begin
                        if (seed_ok) begin
                            idx_next = IDX_W'(seed_val);
                        end else begin
                            err_next = ST_SEED;
                        end
                    end
                    phase_next = PH_HEX_HI;
                end
                PH_HEX_HI: begin
                    if (hex_ok) begin
                        high_next = hex_nib;
                    end else if (err_reg == ST_OK) begin
                        err_next = ST_HEX;
                    end
                    phase_next = PH_HEX_LO;
                end
                PH_HEX_LO: begin
                    if (!hex_ok) begin
                        if (err_reg == ST_OK) err_next = ST_HEX;
                    end else if (err_reg == ST_OK) begin
                        if (overflow) begin
                            err_next = ST_OVER;
                        end else begin
                            result.byte_valid = 1'b1;
                            result.out_byte   = {high_reg, hex_nib} ^
                                                key_byte(8'(idx_reg));
                            idx_next          = IDX_W'(idx_reg + 1'b1);
                        end
                    end
                    phase_next = PH_HEX_HI;
                end
                default: begin
                    phase_next = PH_SEED_HI;
                end
            endcase
        end

        // Report status, including an error raised by this character, and
        // start over after the last character
        if (item.in_last) begin
            result.status = odd ? ST_ODD : err_next;
            phase_next    = PH_SEED_HI;
            tens_next     = 4'd0;
            idx_next      = '0;
            high_next     = 4'd0;
            err_next      = ST_OK;
        end
    end

    // Advance state with each decoded item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEED_HI;
            tens_reg  <= 4'd0;
            idx_reg   <= '0;
            high_reg  <= 4'd0;
            err_reg   <= ST_OK;
        end else if (advance) begin
            phase_reg <= phase_next;
            tens_reg  <= tens_next;
            idx_reg   <= idx_next;
            high_reg  <= high_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ design/t7d_out_stage.sv @@
// ----------------------------------------------------------------------------
// t7d_out_stage: result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module t7d_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  t7d_pkg::result_t result,
    output logic             full,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [3:0]       m_tuser,   // byte_valid, status[2:0]
    output logic             m_tlast    // out_last
);
    import t7d_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign full     = valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.out_byte;
    assign m_tuser  = {res_reg.status, res_reg.byte_valid};
    assign m_tlast  = res_reg.out_last;

    // Track occupancy: fill on load, drain when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Capture result
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

endmodule

@@ design/hex_xor_key_password_decoder.sv @@
// ----------------------------------------------------------------------------
// hex_xor_key_password_decoder: streaming type 7 password decoder
// Decodes an encoded password one character per item into plain bytes.
// ----------------------------------------------------------------------------
// Each input character yields exactly one result item via the input and result
// registers; one character is taken every clock unless the output stalls, set
// by the single decode stage between input and result registers. The first
// two characters are a decimal start index (0 to 15) into the key table, the
// rest are hex digit pairs, each XORed with the next key byte. A result with
// byte_valid set carries a plain byte; the result of the last character
// carries the status (0 ok, 1 odd length, 2 bad seed, 3 bad hex character,
// 4 key table exhausted). After any error no further bytes are produced until
// the string ends, and the decoder is ready for a new string right away.
// ----------------------------------------------------------------------------
module hex_xor_key_password_decoder #(
    parameter int KEY_TABLE_DEPTH = 106
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_char
    input  logic       s_tlast,    // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [3:0] m_tuser,    // byte_valid, status[2:0]
    output logic       m_tlast     // out_last
);
    import t7d_pkg::*;

    logic     item_valid;
    in_item_t item;
    result_t  result;
    logic     out_full;
    logic     advance;

    // Move an item into the result register when it has room
    assign advance = item_valid && (!out_full || m_tready);

    t7d_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    t7d_decode #(
        .KEY_TABLE_DEPTH (KEY_TABLE_DEPTH)
    ) u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    t7d_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .full     (out_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ design/t7d_checker.sv @@
// ----------------------------------------------------------------------------
// t7d_checker: port-level checks of the decoder
// Watches the result channel for stable stalls and consistent status fields.
// ----------------------------------------------------------------------------
module t7d_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);
    import t7d_pkg::*;

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Report status only on the last item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[3:1] == ST_OK)
        else $error("status on a non-last item");

    // Drive zero data when no byte is carried
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("data without byte_valid");

    // A byte on the last item means a clean, even-length string
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tlast |-> m_tuser[3:1] == ST_OK)
        else $error("byte together with error status");

endmodule

bind hex_xor_key_password_decoder t7d_checker u_t7d_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hex_xor_key_password_decoder
// Streams encoded password strings through the decoder one character per
// item, predicts every result item from a local decoder model and checks
// them in order. Covers short and malformed strings, key table exhaustion,
// random gaps on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import t7d_pkg::*;

    localparam int KEY_DEPTH    = 106;
    localparam int SEED_LIMIT   = 15;
    localparam int KEY_LEN      = 53;
    localparam logic [8*KEY_LEN-1:0] KEY_TEXT =
        "dsfd;kfoA,.iyewrkldJKDHSUBsgvca69834ncxv9873254k;fg87";
    localparam int TARGET_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // Character codes
    localparam logic [7:0] DIG_0 = 8'h30;
    localparam logic [7:0] DIG_9 = 8'h39;
    localparam logic [7:0] UP_A  = 8'h41;
    localparam logic [7:0] UP_F  = 8'h46;
    localparam logic [7:0] LO_A  = 8'h61;
    localparam logic [7:0] LO_F  = 8'h66;

    typedef logic [7:0] text_t[$];
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         pause;
    } feed_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // in_char
    logic       s_tlast = 1'b0;     // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // out_byte
    logic [3:0] m_tuser;            // byte_valid, status[2:0]
    logic       m_tlast;            // out_last

    feed_t   feed_q[$];
    result_t decoded_q[$];

    // Local decoder state
    phase_t     dec_phase;
    logic [3:0] dec_tens;
    logic [7:0] dec_index;
    logic [3:0] dec_hi;
    status_t    dec_err;

    int  gap_left = 0;
    int  stall_left = 0;
    int  rx_cycles = 0;
    int  cycle_cnt = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  mismatches = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  bytes_seen = 0;
    int  strings_built = 0;
    int  status_seen[5] = '{default: 0};

    hex_xor_key_password_decoder #(
        .KEY_TABLE_DEPTH(KEY_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Return {valid, value} for a hex digit of either case
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        if (c >= DIG_0 && c <= DIG_9) return {1'b1, c[3:0]};
        if (c >= UP_A && c <= UP_F) return {1'b1, 4'(c - UP_A + 8'd10)};
        if (c >= LO_A && c <= LO_F) return {1'b1, 4'(c - LO_A + 8'd10)};
        return 5'd0;
    endfunction

    function automatic void clear_decoder();
        dec_phase = PH_SEED_HI;
        dec_tens  = 4'd0;
        dec_index = 8'd0;
        dec_hi    = 4'd0;
        dec_err   = ST_OK;
    endfunction

    // Keep only the first error of a string
    function automatic void latch_error(input status_t e);
        if (dec_err == ST_OK) dec_err = e;
    endfunction

    // Advance the local decoder by one character and return its result item
    function automatic result_t decode_char(input logic [7:0] c, input logic last);
        result_t    r;
        logic [4:0] hx;
        logic       is_digit;
        logic       odd_len;
        int         seed;
        int         kpos;
        hx = hex_lookup(c);
        is_digit = (c >= DIG_0 && c <= DIG_9);
        odd_len = (dec_phase == PH_SEED_HI || dec_phase == PH_HEX_HI);
        r.byte_valid = 1'b0;
        r.out_byte = 8'h00;
        r.out_last = last;
        r.status = ST_OK;
        // a final character at an odd position is not decoded at all
        if (!(last && odd_len)) begin
            case (dec_phase)
                PH_SEED_HI: begin
                    if (is_digit) dec_tens = c[3:0];
                    else latch_error(ST_SEED);
                    dec_phase = PH_SEED_LO;
                end
                PH_SEED_LO: begin
                    seed = int'(dec_tens) * 10 + int'(c[3:0]);
                    if (dec_err == ST_OK) begin
                        if (is_digit && seed <= SEED_LIMIT) dec_index = 8'(seed);
                        else latch_error(ST_SEED);
                    end
                    dec_phase = PH_HEX_HI;
                end
                PH_HEX_HI: begin
                    if (hx[4]) dec_hi = hx[3:0];
                    else latch_error(ST_HEX);
                    dec_phase = PH_HEX_LO;
                end
                default: begin
                    if (!hx[4]) begin
                        latch_error(ST_HEX);
                    end else if (dec_err == ST_OK) begin
                        if (int'(dec_index) >= KEY_DEPTH) begin
                            latch_error(ST_OVER);
                        end else begin
                            kpos = int'(dec_index) % KEY_LEN;
                            r.out_byte = {dec_hi, hx[3:0]} ^ KEY_TEXT[8*(KEY_LEN-1-kpos) +: 8];
                            r.byte_valid = 1'b1;
                            dec_index = dec_index + 8'd1;
                        end
                    end
                    dec_phase = PH_HEX_HI;
                end
            endcase
        end
        if (last) begin
            r.status = odd_len ? ST_ODD : dec_err;
            clear_decoder();
        end
        return r;
    endfunction

    // Stimulus helpers
    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) return 8'(int'(DIG_0) + v);
        return 8'(int'(upper ? UP_A : LO_A) + v - 10);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c >= DIG_0 && c <= DIG_9);
        return c;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [4:0] hx;
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
            hx = hex_lookup(c);
        end while (hx[4]);
        return c;
    endfunction

    function automatic text_t from_str(input string s);
        text_t t;
        foreach (s[i]) t.push_back(s[i]);
        return t;
    endfunction

    function automatic text_t good_text(input int seed, input int pairs);
        text_t t;
        t.push_back(8'(int'(DIG_0) + seed / 10));
        t.push_back(8'(int'(DIG_0) + seed % 10));
        repeat (2 * pairs) t.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
        return t;
    endfunction

    // Mostly well-formed strings, the rest broken in one way or pure noise
    function automatic text_t random_text();
        text_t t;
        int    pick;
        int    seed;
        int    pairs;
        pick = $urandom_range(0, 99);
        seed = $urandom_range(0, SEED_LIMIT);
        if ($urandom_range(0, 99) < 2)
            pairs = KEY_DEPTH - seed - 1 + $urandom_range(0, 3);
        else
            pairs = $urandom_range(0, 12);
        t = good_text(seed, pairs);
        if (pick < 10) begin
            // bad seed: non-digit or too large
            if ($urandom_range(0, 1)) begin
                t[$urandom_range(0, 1)] = non_digit();
            end else begin
                seed = $urandom_range(16, 99);
                t[0] = 8'(int'(DIG_0) + seed / 10);
                t[1] = 8'(int'(DIG_0) + seed % 10);
            end
        end else if (pick < 20) begin
            // bad hex character somewhere in the pairs
            if (t.size() == 2) begin
                t.push_back(hex_char($urandom_range(0, 15), 1'b0));
                t.push_back(hex_char($urandom_range(0, 15), 1'b1));
            end
            t[$urandom_range(2, t.size() - 1)] = non_hex();
        end else if (pick < 27) begin
            // odd length
            if (t.size() < 3 || $urandom_range(0, 1))
                t.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            else
                void'(t.pop_back());
        end else if (pick < 32) begin
            // noise
            t.delete();
            repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
        end
        return t;
    endfunction

    task automatic add_text(input text_t t);
        foreach (t[i]) feed_q.push_back('{ch: t[i], last: (i == t.size() - 1), pause: 1'b0});
        strings_built++;
    endtask

    task automatic add_pause();
        feed_q.push_back('{ch: 8'h00, last: 1'b0, pause: 1'b1});
    endtask

    // Count queued characters, not pauses
    function automatic int items_queued();
        int n;
        n = 0;
        foreach (feed_q[i]) if (!feed_q[i].pause) n++;
        return n;
    endfunction

    // Gap before the next item: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 199) == 0) tx_quiet = !tx_quiet;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    // Clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Sender: offer queued items, honor gaps and drain pauses
    always @(posedge aclk) begin
        feed_t nxt_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decoded_q.push_back(decode_char(s_tdata, s_tlast));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (feed_q.size() > 0 && feed_q[0].pause) begin
                    // hold until every expected result is back
                    if (decoded_q.size() == 0) void'(feed_q.pop_front());
                    s_tvalid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    nxt_item = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt_item.ch;
                    s_tlast <= nxt_item.last;
                    gap_left <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result item, stall at random, one long hold-off
    always @(posedge aclk) begin
        result_t want;
        int      r;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
            rx_cycles <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser[0] === 1'b1) bytes_seen++;
                if (m_tlast === 1'b1 && m_tuser[3:1] < 3'd5) status_seen[m_tuser[3:1]]++;
                if (decoded_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result byte %h valid %b last %b status %0d",
                        m_tdata, m_tuser[0], m_tlast, m_tuser[3:1]));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser[0] !== want.byte_valid || m_tdata !== want.out_byte ||
                        m_tlast !== want.out_last || m_tuser[3:1] !== want.status)
                        note_mismatch($sformatf(
                            "expected valid %b byte %h last %b status %0d, got %b %h %b %0d",
                            want.byte_valid, want.out_byte, want.out_last, want.status,
                            m_tuser[0], m_tdata, m_tlast, m_tuser[3:1]));
                end
            end
            if (rx_cycles == HOLD_AT) begin
                stall_left <= HOLD_LEN;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
                r = $urandom_range(0, 99);
                if (rx_quiet || r < 75) begin
                    m_tready <= 1'b1;
                end else if (r < 97) begin
                    stall_left <= $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    stall_left <= $urandom_range(8, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_cnt, decoded_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Build the stimulus, run reset, wait for the decoder to drain
    initial begin
        text_t t;
        bit    mid_pause;
        mid_pause = 1'b0;
        clear_decoder();

        // directed: short strings, seed limits, both cases, each status
        add_text(from_str("5"));
        add_text(from_str("07"));
        add_text(from_str("15Ff"));
        add_text(from_str("1600"));
        add_text(from_str("0a"));
        add_text(from_str("000G"));
        add_text(from_str("091"));
        add_text(from_str("12zzA"));
        t.delete();
        t.push_back(8'hFF);
        t.push_back(8'h00);
        add_text(t);
        add_pause();

        // run the key table out from the highest seed
        add_text(good_text(SEED_LIMIT, KEY_DEPTH - SEED_LIMIT + 1));

        while (items_queued() < TARGET_ITEMS) begin
            if (!mid_pause && items_queued() > TARGET_ITEMS / 2) begin
                add_pause();
                mid_pause = 1'b1;
            end
            add_text(random_text());
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d strings, %0d characters, %0d results, %0d plain bytes",
            strings_built, items_sent, results_seen, bytes_seen);
        $display("final status: ok %0d, odd %0d, seed %0d, hex %0d, overflow %0d; %0d mismatches",
            status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
            mismatches);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
